>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property shorthands for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NFA_ASSERT_IMP(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("assertion failed");

// next-cycle implication
`define NFA_ASSERT_NXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("assertion failed");

`endif

>>> rtl/nfa_pkg.sv
// ----------------------------------------------------------------------------
// nfa_pkg
// Types, codes and the character class test for the NFA matcher.
// ----------------------------------------------------------------------------
package nfa_pkg;

	localparam int NUM_STATES      = 64;
	localparam int EDGES_PER_STATE = 8;
	localparam int STATE_W         = $clog2(NUM_STATES);
	localparam int EIDX_W          = $clog2(EDGES_PER_STATE);
	localparam int CNT_W           = $clog2(EDGES_PER_STATE + 1);
	localparam int EDGE_W          = STATE_W + 4 + 8 + 8;
	localparam int EDGE_DEPTH      = NUM_STATES * EDGES_PER_STATE;

	localparam logic [2:0] CMD_CLEAR  = 3'd0;
	localparam logic [2:0] CMD_APPEND = 3'd1;
	localparam logic [2:0] CMD_FINAL  = 3'd2;
	localparam logic [2:0] CMD_START  = 3'd3;
	localparam logic [2:0] CMD_CHAR   = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic [3:0] CLS_EPS    = 4'd0;
	localparam logic [3:0] CLS_CHAR   = 4'd1;
	localparam logic [3:0] CLS_RANGE  = 4'd2;
	localparam logic [3:0] CLS_SPACE  = 4'd3;
	localparam logic [3:0] CLS_WORD   = 4'd4;
	localparam logic [3:0] CLS_DIGIT  = 4'd5;
	localparam logic [3:0] CLS_NL     = 4'd6;
	localparam logic [3:0] CLS_ANY    = 4'd7;
	localparam logic [3:0] CLS_CONJ   = 4'd8;
	localparam logic [3:0] CLS_NCHAR  = 4'd9;
	localparam logic [3:0] CLS_NRANGE = 4'd10;
	localparam logic [3:0] CLS_NSPACE = 4'd11;
	localparam logic [3:0] CLS_NWORD  = 4'd12;
	localparam logic [3:0] CLS_NDIGIT = 4'd13;
	localparam logic [3:0] CLS_NNL    = 4'd14;
	localparam logic [3:0] CLS_NONE   = 4'd15;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_CLEAR, OP_MARK, OP_CNT_RD, OP_APPEND, OP_START,
		OP_MOVE_INIT, OP_SCAN, OP_CNT, OP_EDGE, OP_RESTART, OP_COMMIT, OP_RESULT
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_APP_RD, S_SCAN, S_CNT, S_EDGE, S_PASS_END, S_DONE
	} fsm_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       hit;
		logic       q_last;
		logic       n_zero;
		logic       k_last;
		logic       mode_move;
		logic       grew;
		logic       out_busy;
	} dp_stat_t;

	function automatic logic edge_accepts(logic [3:0] cls, logic [7:0] lo,
			logic [7:0] hi, logic [7:0] c);
		logic sp, dg, wd, nl, rg, r;
		sp = (c >= 8'h09) && (c <= 8'h0d);
		dg = (c >= 8'h30) && (c <= 8'h39);
		wd = dg || ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
			|| (c == 8'h5f);
		nl = (c == 8'h0a) || (c == 8'h0d);
		rg = (lo <= c) && (c <= hi);
		case (cls)
			CLS_CHAR:   r = (c == lo);
			CLS_RANGE:  r = rg;
			CLS_SPACE:  r = sp;
			CLS_WORD:   r = wd;
			CLS_DIGIT:  r = dg;
			CLS_NL:     r = nl;
			CLS_ANY:    r = 1'b1;
			CLS_NCHAR:  r = (c != lo);
			CLS_NRANGE: r = !rg;
			CLS_NSPACE: r = !sp;
			CLS_NWORD:  r = !wd;
			CLS_NDIGIT: r = !dg;
			CLS_NNL:    r = !nl;
			default:    r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/nfa_in_if.sv
// ----------------------------------------------------------------------------
// nfa_in_if
// Command word channel.
// ----------------------------------------------------------------------------
interface nfa_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [5:0] state_index;
	logic [5:0] dst_state;
	logic [3:0] edge_class;
	logic [7:0] range_low;
	logic [7:0] range_high;
	logic [7:0] char_in;

	modport source (output valid, cmd, state_index, dst_state, edge_class,
		range_low, range_high, char_in, input ready);
	modport sink (input valid, cmd, state_index, dst_state, edge_class,
		range_low, range_high, char_in, output ready);
endinterface

>>> rtl/nfa_out_if.sv
// ----------------------------------------------------------------------------
// nfa_out_if
// Result word channel.
// ----------------------------------------------------------------------------
interface nfa_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       alive;
	logic       accepted;

	modport source (output valid, status, alive, accepted, input ready);
	modport sink (input valid, status, alive, accepted, output ready);
endinterface

>>> rtl/nfa_ram.sv
// ----------------------------------------------------------------------------
// nfa_ram
// Single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module nfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/nfa_dp.sv
// ----------------------------------------------------------------------------
// nfa_dp
// Datapath: edge and count stores, state sets, walk counters, result register.
// ----------------------------------------------------------------------------
module nfa_dp import nfa_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  op_t            op,
	output dp_stat_t       stat,
	input  logic           cfg_we,
	input  logic [5:0]     cfg_wdata,
	input  logic [2:0]     cmd,
	input  logic [5:0]     state_index,
	input  logic [5:0]     dst_state,
	input  logic [3:0]     edge_class,
	input  logic [7:0]     range_low,
	input  logic [7:0]     range_high,
	input  logic [7:0]     char_in,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     out_status,
	output logic           out_alive,
	output logic           out_accepted
);
	logic [2:0]            cmd_q;
	logic [STATE_W-1:0]    src_q, dst_q, q_q, conj_tgt_q, state_count_q;
	logic [3:0]            cls_q;
	logic [7:0]            lo_q, hi_q, chr_q;
	logic [NUM_STATES-1:0] final_q, active_q, work_q, cnt_valid_q;
	logic [EIDX_W-1:0]     k_q;
	logic [CNT_W-1:0]      n_q;
	logic                  mode_move_q, grew_q, conj_q, all_q;
	logic [1:0]            status_q;
	logic                  out_valid_q, out_alive_q, out_acc_q;
	logic [1:0]            out_status_q;

	logic [STATE_W-1:0]    cnt_raddr;
	logic [CNT_W-1:0]      cnt_rdata, cnt_eff;
	logic                  cnt_vld_s1;
	logic [$clog2(EDGE_DEPTH)-1:0] e_raddr, e_waddr;
	logic [EDGE_W-1:0]     e_rdata;
	logic [STATE_W-1:0]    e_tgt, tgt_now;
	logic [3:0]            e_cls;
	logic [7:0]            e_lo, e_hi;
	logic                  e_acc, is_marker, conj_now, all_now, k_last, app_we;
	logic                  src_ok, dst_ok;

	assign cnt_raddr = (op == OP_CNT_RD) ? src_q : q_q;
	assign cnt_eff   = cnt_vld_s1 ? cnt_rdata : '0;
	assign e_raddr   = {q_q, (op == OP_EDGE) ? k_q + 1'b1 : EIDX_W'(0)};
	assign e_waddr   = {src_q, cnt_eff[EIDX_W-1:0]};
	assign src_ok    = src_q <= state_count_q;
	assign dst_ok    = dst_q <= state_count_q;
	assign app_we    = (op == OP_APPEND) && src_ok && dst_ok
		&& (cnt_eff < CNT_W'(EDGES_PER_STATE));

	assign {e_tgt, e_cls, e_lo, e_hi} = e_rdata;
	assign e_acc     = edge_accepts(e_cls, e_lo, e_hi, chr_q);
	assign is_marker = (k_q == '0) && (e_cls == CLS_CONJ);
	assign conj_now  = conj_q || is_marker;
	assign all_now   = all_q && (is_marker || e_acc);
	assign tgt_now   = is_marker ? e_tgt : conj_tgt_q;
	assign k_last    = (CNT_W'(k_q) + 1'b1) == n_q;

	nfa_ram #(.WIDTH(CNT_W), .DEPTH(NUM_STATES)) u_cnt_ram (
		.clk(clk), .we(app_we), .waddr(src_q), .wdata(cnt_eff + 1'b1),
		.raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	nfa_ram #(.WIDTH(EDGE_W), .DEPTH(EDGE_DEPTH)) u_edge_ram (
		.clk(clk), .we(app_we), .waddr(e_waddr),
		.wdata({dst_q, cls_q, lo_q, hi_q}), .raddr(e_raddr), .rdata(e_rdata)
	);

	always_ff @(posedge clk) begin
		cnt_vld_s1 <= cnt_valid_q[cnt_raddr];
		if (op == OP_LOAD) begin
			cmd_q <= cmd;
			src_q <= state_index;
			dst_q <= dst_state;
			cls_q <= edge_class;
			lo_q  <= range_low;
			hi_q  <= range_high;
			chr_q <= char_in;
		end
		if (op == OP_CNT) begin
			n_q <= cnt_eff;
		end
		if (op == OP_EDGE && is_marker) begin
			conj_tgt_q <= e_tgt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_count_q <= '0;
			final_q       <= '0;
			active_q      <= '0;
			work_q        <= '0;
			cnt_valid_q   <= '0;
			q_q           <= '0;
			k_q           <= '0;
			mode_move_q   <= 1'b0;
			grew_q        <= 1'b0;
			conj_q        <= 1'b0;
			all_q         <= 1'b0;
			status_q      <= ST_OK;
			out_valid_q   <= 1'b0;
			out_status_q  <= ST_OK;
			out_alive_q   <= 1'b0;
			out_acc_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				state_count_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (op)
				OP_LOAD: status_q <= ST_OK;
				OP_CLEAR: begin
					cnt_valid_q <= '0;
					final_q     <= '0;
					active_q    <= '0;
				end
				OP_MARK: begin
					if (src_ok) final_q[src_q] <= 1'b1;
					else status_q <= ST_RANGE;
				end
				OP_APPEND: begin
					if (!src_ok || !dst_ok) begin
						status_q <= ST_RANGE;
					end else if (!app_we) begin
						status_q <= ST_FULL;
					end else begin
						cnt_valid_q[src_q] <= 1'b1;
					end
				end
				OP_START: begin
					work_q      <= NUM_STATES'(1);
					q_q         <= '0;
					mode_move_q <= 1'b0;
					grew_q      <= 1'b0;
				end
				OP_MOVE_INIT: begin
					work_q      <= '0;
					q_q         <= '0;
					mode_move_q <= 1'b1;
				end
				OP_RESTART: begin
					q_q         <= '0;
					mode_move_q <= 1'b0;
					grew_q      <= 1'b0;
				end
				OP_SCAN: begin
					if (!stat.hit) q_q <= q_q + 1'b1;
				end
				OP_CNT: begin
					k_q    <= '0;
					conj_q <= 1'b0;
					all_q  <= 1'b1;
					if (cnt_eff == '0) q_q <= q_q + 1'b1;
				end
				OP_EDGE: begin
					k_q    <= k_q + 1'b1;
					conj_q <= conj_now;
					all_q  <= all_now;
					if (mode_move_q) begin
						if (conj_now) begin
							if (k_last && all_now) work_q[tgt_now] <= 1'b1;
						end else if (e_acc) begin
							work_q[e_tgt] <= 1'b1;
						end
					end else if (e_cls == CLS_EPS && !work_q[e_tgt]) begin
						work_q[e_tgt] <= 1'b1;
						grew_q        <= 1'b1;
					end
					if (k_last) q_q <= q_q + 1'b1;
				end
				OP_COMMIT: active_q <= work_q;
				OP_RESULT: begin
					out_valid_q  <= 1'b1;
					out_status_q <= status_q;
					out_alive_q  <= |active_q;
					out_acc_q    <= |(active_q & final_q);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		stat.cmd       = cmd_q;
		stat.hit       = mode_move_q ? active_q[q_q] : work_q[q_q];
		stat.q_last    = &q_q;
		stat.n_zero    = (cnt_eff == '0);
		stat.k_last    = k_last;
		stat.mode_move = mode_move_q;
		stat.grew      = grew_q;
		stat.out_busy  = out_valid_q && !out_ready;
	end

	assign out_valid    = out_valid_q;
	assign out_status   = out_status_q;
	assign out_alive    = out_alive_q;
	assign out_accepted = out_acc_q;
endmodule

>>> rtl/nfa_ctrl.sv
// ----------------------------------------------------------------------------
// nfa_ctrl
// Sequencer for command words: dispatch, state scan, edge walk, closure passes.
// ----------------------------------------------------------------------------
module nfa_ctrl import nfa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output op_t      op
);
	fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		op       = OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = !stat.out_busy;
				if (in_valid && !stat.out_busy) begin
					op      = OP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (stat.cmd)
					CMD_CLEAR: begin
						op      = OP_CLEAR;
						state_d = S_DONE;
					end
					CMD_APPEND: begin
						op      = OP_CNT_RD;
						state_d = S_APP_RD;
					end
					CMD_FINAL: begin
						op      = OP_MARK;
						state_d = S_DONE;
					end
					CMD_START: begin
						op      = OP_START;
						state_d = S_SCAN;
					end
					CMD_CHAR: begin
						op      = OP_MOVE_INIT;
						state_d = S_SCAN;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_APP_RD: begin
				op      = OP_APPEND;
				state_d = S_DONE;
			end
			S_SCAN: begin
				op = OP_SCAN;
				if (stat.hit) state_d = S_CNT;
				else if (stat.q_last) state_d = S_PASS_END;
			end
			S_CNT: begin
				op = OP_CNT;
				if (!stat.n_zero) state_d = S_EDGE;
				else state_d = stat.q_last ? S_PASS_END : S_SCAN;
			end
			S_EDGE: begin
				op = OP_EDGE;
				if (stat.k_last) state_d = stat.q_last ? S_PASS_END : S_SCAN;
			end
			S_PASS_END: begin
				if (stat.mode_move || stat.grew) begin
					op      = OP_RESTART;
					state_d = S_SCAN;
				end else begin
					op      = OP_COMMIT;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				op      = OP_RESULT;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

>>> rtl/nfa_char_class_matcher.sv
// Clear, mark final and unused commands: load, dispatch, then the result word; append
// loads, reads the edge count at dispatch, writes the edge, then gives the result word.
// Start and character: dispatch, a move pass (character only) and closure passes,
// each scanning every state, walking the edges of each active state and ending in a
// pass-end step, repeated until the closure stops growing; then the result word.
// One word in flight at a time. Async reset empties sets and edge counts.
// ----------------------------------------------------------------------------
// nfa_char_class_matcher
// NFA simulator with loadable edge table and character classes.
// ----------------------------------------------------------------------------
module nfa_char_class_matcher import nfa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	nfa_in_if.sink     in_ch,
	nfa_out_if.source  out_ch,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata
);
	op_t      op;
	dp_stat_t stat;

	nfa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.stat(stat), .op(op)
	);

	nfa_dp u_dp (
		.clk(clk), .arst_n(arst_n), .op(op), .stat(stat),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.cmd(in_ch.cmd), .state_index(in_ch.state_index),
		.dst_state(in_ch.dst_state), .edge_class(in_ch.edge_class),
		.range_low(in_ch.range_low), .range_high(in_ch.range_high),
		.char_in(in_ch.char_in),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_status(out_ch.status), .out_alive(out_ch.alive),
		.out_accepted(out_ch.accepted)
	);
endmodule

>>> rtl/nfa_chk.sv
// ----------------------------------------------------------------------------
// nfa_chk
// Port-level checks for the matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nfa_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic       alive,
	input logic       accepted
);
	`NFA_ASSERT_NXT(a_one_word, clk, arst_n, in_valid && in_ready, !in_ready)
	`NFA_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`NFA_ASSERT_IMP(a_status_code, clk, arst_n, out_valid, status != 2'd3)
	`NFA_ASSERT_IMP(a_acc_alive, clk, arst_n, out_valid && accepted, alive)
endmodule

bind nfa_char_class_matcher nfa_chk u_nfa_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.status(out_ch.status), .alive(out_ch.alive), .accepted(out_ch.accepted)
);
